// ----- src/slcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_pkg
// Shared types and constants for the sync/length/checksum deframer.
// ----------------------------------------------------------------------------
package slcd_pkg;

    localparam logic [7:0] SYNC_RESET = 8'h5A;
    localparam logic [7:0] BYTE_MASK  = 8'hFF;

    // Register indexes (byte address = 4 * index)
    localparam logic REG_SYNC_VALUE = 1'b0;
    localparam logic REG_RAW_MODE   = 1'b1;

    localparam int PADDR_W = 3;

    // Result queue between parser and output stage
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_RAW   = 2'd2,
        KIND_UNUSED = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  command;
        logic [7:0]  sub_command;
        logic [7:0]  data_byte;
        logic [15:0] data_index;
        logic [15:0] payload_length;
        logic        frame_last;
        logic        checksum_good;
    } t_result;

    typedef struct packed {
        logic [7:0] sync_value;
        logic       raw_mode;
    } t_cfg;

endpackage

// ----- src/slcd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_front
// Byte parser: hunts for sync, tracks frame fields, emits result records.
// ----------------------------------------------------------------------------
module slcd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  slcd_pkg::t_cfg    i_cfg,
    input  logic              i_accept,
    input  logic [7:0]        i_rx_byte,
    output logic              o_push,
    output slcd_pkg::t_result o_result
);

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_CMD    = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_LEN_HI = 3'd3,
        PH_SUB    = 3'd4,
        PH_DATA   = 3'd5,
        PH_CHECK  = 3'd6
    } t_phase;

    t_phase      r_phase,   n_phase;
    logic [7:0]  r_command, n_command;
    logic [7:0]  r_sub,     n_sub;
    logic [15:0] r_len,     n_len;
    logic [15:0] r_count,   n_count;
    logic [7:0]  r_sum,     n_sum;

    logic [16:0] w_count_inc;
    logic [7:0]  w_sum_add;

    assign w_count_inc = {1'b0, r_count} + 17'd1;
    assign w_sum_add   = r_sum + i_rx_byte;

    always_comb begin
        n_phase   = r_phase;
        n_command = r_command;
        n_sub     = r_sub;
        n_len     = r_len;
        n_count   = r_count;
        n_sum     = r_sum;
        o_push    = 1'b0;
        o_result  = '0;
        o_result.command        = r_command;
        o_result.sub_command    = r_sub;
        o_result.payload_length = r_len;

        if (i_cfg.raw_mode) begin
            // passthrough; any partial frame is dropped
            n_phase   = PH_HUNT;
            n_command = '0;
            n_sub     = '0;
            n_len     = '0;
            n_count   = '0;
            n_sum     = '0;
            o_push    = 1'b1;
            o_result  = '0;
            o_result.kind      = slcd_pkg::KIND_RAW;
            o_result.data_byte = i_rx_byte;
        end else begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == i_cfg.sync_value) begin
                        n_phase   = PH_CMD;
                        n_command = '0;
                        n_sub     = '0;
                        n_len     = '0;
                        n_count   = '0;
                        n_sum     = '0;
                    end
                end
                PH_CMD: begin
                    n_command = i_rx_byte;
                    n_sum     = i_rx_byte;
                    n_phase   = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_len   = {8'h00, i_rx_byte};
                    n_sum   = w_sum_add;
                    n_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_len   = {i_rx_byte, r_len[7:0]};
                    n_sum   = w_sum_add;
                    n_phase = ({i_rx_byte, r_len[7:0]} == 16'd0) ? PH_CHECK : PH_SUB;
                end
                PH_SUB: begin
                    n_sub   = i_rx_byte;
                    n_sum   = w_sum_add;
                    n_count = 16'd1;
                    n_phase = (r_len == 16'd1) ? PH_CHECK : PH_DATA;
                end
                PH_DATA: begin
                    n_sum   = w_sum_add;
                    o_push  = 1'b1;
                    o_result.kind       = slcd_pkg::KIND_DATA;
                    o_result.data_byte  = i_rx_byte;
                    o_result.data_index = r_count - 16'd1;
                    if (w_count_inc >= {1'b0, r_len}) n_phase = PH_CHECK;
                    n_count = w_count_inc[15:0];
                end
                PH_CHECK: begin
                    o_push = 1'b1;
                    o_result.kind          = slcd_pkg::KIND_END;
                    o_result.frame_last    = 1'b1;
                    o_result.checksum_good = ((r_sum ^ slcd_pkg::BYTE_MASK) == i_rx_byte);
                    n_phase   = PH_HUNT;
                    n_command = '0;
                    n_sub     = '0;
                    n_len     = '0;
                    n_count   = '0;
                    n_sum     = '0;
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end

        if (!i_accept) begin
            o_push = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_command <= '0;
            r_sub     <= '0;
            r_len     <= '0;
            r_count   <= '0;
            r_sum     <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_command <= n_command;
            r_sub     <= n_sub;
            r_len     <= n_len;
            r_count   <= n_count;
            r_sum     <= n_sum;
        end
    end

endmodule

// ----- src/slcd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_queue
// Small result FIFO between the parser and the output stage.
// ----------------------------------------------------------------------------
module slcd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  slcd_pkg::t_result i_data,
    input  logic              i_pop,
    output slcd_pkg::t_result o_data,
    output logic              o_empty,
    output logic              o_full
);

    slcd_pkg::t_result r_mem [slcd_pkg::QDEPTH];
    logic [slcd_pkg::QAW-1:0] r_wr_ptr;
    logic [slcd_pkg::QAW-1:0] r_rd_ptr;
    logic [slcd_pkg::QCW-1:0] r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == slcd_pkg::QCW'(slcd_pkg::QDEPTH));
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !i_pop |-> !i_push)
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("result queue underflow");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_empty || o_full) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

    a_end_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (i_data.frame_last == (i_data.kind == slcd_pkg::KIND_END)))
        else $error("frame_last pushed on a non-end result");

endmodule

// ----- src/slcd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_back
// Output register stage: drains the result queue onto the output channel.
// ----------------------------------------------------------------------------
module slcd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  slcd_pkg::t_result i_q_data,
    output logic              o_q_pop,
    input  logic              i_stall,
    output logic              o_valid,
    output slcd_pkg::t_result o_result
);

    logic              r_valid;
    slcd_pkg::t_result r_result;

    assign o_q_pop  = !i_q_empty && (!r_valid || !i_stall);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_result <= i_q_data;
        end
    end

endmodule

// ----- src/sync_length_checksum_deframer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer
// Byte-stream frame parser with sync hunt, length field and checksum check.
// ----------------------------------------------------------------------------
// Takes one received byte per item and accepts a new byte every cycle. Bytes
// are dropped until the sync byte (register 0, reset 0x5A) is seen; then a
// command byte, a little-endian 16-bit payload length, the payload and one
// checksum byte follow. The first payload byte is the sub-command; each later
// payload byte leaves as a data item (kind 0) with its index. The checksum
// byte yields a frame-end item (kind 1) whose checksum_good says whether it
// equals the inverted 8-bit sum of command, length bytes and payload. With
// raw_mode (register 1) set, each byte leaves unparsed as kind 2. A byte's
// result is written into the queue when the byte is accepted, then moves on
// into the output register, from which it leaves once i_out_stall is low.
// The parser keeps the full rate as long as the four-entry result queue and
// the output register are not backed up by i_out_stall, in which case
// o_rx_stall rises once the queue is full.
// Registers sit at byte addresses 0 and 4 of the APB port; write them only
// while the block is idle.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [slcd_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,

    // Received byte channel
    input  logic                          i_rx_valid,
    output logic                          o_rx_stall,
    input  logic [7:0]                    i_rx_byte,

    // Result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_out_kind,
    output logic [7:0]                    o_command,
    output logic [7:0]                    o_sub_command,
    output logic [7:0]                    o_data_byte,
    output logic [15:0]                   o_data_index,
    output logic [15:0]                   o_payload_length,
    output logic                          o_frame_last,
    output logic                          o_checksum_good
);

    // ---- configuration registers ----
    slcd_pkg::t_cfg r_cfg;
    logic           w_cfg_wr;
    logic           w_reg_sel;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_sel = paddr[2];   // register index = address / 4

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_value <= slcd_pkg::SYNC_RESET;
            r_cfg.raw_mode   <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (w_reg_sel)
                slcd_pkg::REG_SYNC_VALUE: r_cfg.sync_value <= pwdata[7:0];
                slcd_pkg::REG_RAW_MODE:   r_cfg.raw_mode   <= pwdata[0];
                default:                  r_cfg            <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_sel)
            slcd_pkg::REG_SYNC_VALUE: prdata = {24'd0, r_cfg.sync_value};
            slcd_pkg::REG_RAW_MODE:   prdata = {31'd0, r_cfg.raw_mode};
            default:                  prdata = '0;
        endcase
    end

    // ---- front: parser ----
    // The input side only looks at the queue's registered full flag, so the
    // output stall never reaches o_rx_stall combinationally.
    logic              w_q_full;
    logic              w_q_empty;
    logic              w_rx_accept;
    logic              w_push;
    logic              w_pop;
    slcd_pkg::t_result w_front_res;
    slcd_pkg::t_result w_q_data;
    slcd_pkg::t_result w_out_res;

    assign o_rx_stall  = w_q_full;
    assign w_rx_accept = i_rx_valid && !w_q_full;

    slcd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_accept  (w_rx_accept),
        .i_rx_byte (i_rx_byte),
        .o_push    (w_push),
        .o_result  (w_front_res)
    );

    // ---- queue between parser and output ----
    slcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_res),
        .i_pop   (w_pop),
        .o_data  (w_q_data),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    // ---- back: output register ----
    slcd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_q_data  (w_q_data),
        .o_q_pop   (w_pop),
        .i_stall   (i_out_stall),
        .o_valid   (o_out_valid),
        .o_result  (w_out_res)
    );

    assign o_out_kind       = w_out_res.kind;
    assign o_command        = w_out_res.command;
    assign o_sub_command    = w_out_res.sub_command;
    assign o_data_byte      = w_out_res.data_byte;
    assign o_data_index     = w_out_res.data_index;
    assign o_payload_length = w_out_res.payload_length;
    assign o_frame_last     = w_out_res.frame_last;
    assign o_checksum_good  = w_out_res.checksum_good;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sync/length/checksum deframer.
// ----------------------------------------------------------------------------
// Drives received bytes through the valid/stall input channel and checks
// every output item against a cycle-free model of the parser kept in this
// file. The model runs when a byte is accepted and queues the item the byte
// should produce; the output monitor pops the oldest entry for each accepted
// output and compares it field by field. Stimulus is a short set of frame
// shapes, a raw-mode switch in the middle of a frame, random traffic built
// mostly from well-formed frames under three handshake pressure settings,
// and a frame with the largest length field cut short by raw mode.
// ----------------------------------------------------------------------------
module testbench;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
    localparam int DRAIN_CYCLES   = 6;     // margin for the queue and output register to empty
    localparam int SEGMENT_ITEMS  = 100;   // bytes per register setting
    localparam int LONG_PAYLOAD   = 40;    // payload bytes sent of the long frame

    // Parser states of the model
    typedef enum logic [2:0] {
        ST_HUNT, ST_CMD, ST_LEN_LO, ST_LEN_HI, ST_SUB, ST_DATA, ST_CHECK
    } t_parse_state;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [slcd_pkg::PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_rx_valid;
    logic        o_rx_stall;
    logic [7:0]  i_rx_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_out_kind;
    logic [7:0]  o_command;
    logic [7:0]  o_sub_command;
    logic [7:0]  o_data_byte;
    logic [15:0] o_data_index;
    logic [15:0] o_payload_length;
    logic        o_frame_last;
    logic        o_checksum_good;

    sync_length_checksum_deframer i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_rx_valid       (i_rx_valid),
        .o_rx_stall       (o_rx_stall),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_kind       (o_out_kind),
        .o_command        (o_command),
        .o_sub_command    (o_sub_command),
        .o_data_byte      (o_data_byte),
        .o_data_index     (o_data_index),
        .o_payload_length (o_payload_length),
        .o_frame_last     (o_frame_last),
        .o_checksum_good  (o_checksum_good)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Register copies and parser state of the model
    logic [7:0]   cfg_sync;
    logic         cfg_raw;
    t_parse_state ps_state;
    logic [7:0]   ps_cmd;
    logic [7:0]   ps_sub;
    logic [15:0]  ps_len;
    logic [15:0]  ps_count;
    logic [7:0]   ps_sum;

    slcd_pkg::t_result expected_results[$];
    slcd_pkg::t_result out_expect;

    int tx_idle_pct;
    int rx_stall_pct;
    int items_sent;
    int frames_sent;
    int results_checked;
    int mismatch_count;
    int quiet_cycles;
    int seg_count;

    // ------------------------------------------------------------------------
    // Model of the parser
    // ------------------------------------------------------------------------
    function automatic void clear_frame();
        ps_state = ST_HUNT;
        ps_cmd   = '0;
        ps_sub   = '0;
        ps_len   = '0;
        ps_count = '0;
        ps_sum   = '0;
    endfunction

    // Appends one item to the tail of the expected list.
    function automatic void expect_item(input slcd_pkg::t_result r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    // Advances the model by one accepted byte and queues the item it yields.
    function automatic void predict_byte(input logic [7:0] b);
        slcd_pkg::t_result r;
        r = '0;
        if (cfg_raw) begin
            // raw bytes also drop any frame in progress
            clear_frame();
            r.kind      = slcd_pkg::KIND_RAW;
            r.data_byte = b;
            expect_item(r);
            return;
        end
        case (ps_state)
            ST_HUNT: begin
                if (b == cfg_sync) begin
                    clear_frame();
                    ps_state = ST_CMD;
                end
            end
            ST_CMD: begin
                ps_cmd   = b;
                ps_sum   = b;
                ps_state = ST_LEN_LO;
            end
            ST_LEN_LO: begin
                ps_len   = {8'h00, b};
                ps_sum   = ps_sum + b;
                ps_state = ST_LEN_HI;
            end
            ST_LEN_HI: begin
                ps_len[15:8] = b;
                ps_sum       = ps_sum + b;
                // empty payload goes straight to the checksum byte
                ps_state     = (ps_len == 16'd0) ? ST_CHECK : ST_SUB;
            end
            ST_SUB: begin
                ps_sub   = b;
                ps_sum   = ps_sum + b;
                ps_count = 16'd1;
                ps_state = (ps_len <= 16'd1) ? ST_CHECK : ST_DATA;
            end
            ST_DATA: begin
                ps_sum           = ps_sum + b;
                r.kind           = slcd_pkg::KIND_DATA;
                r.command        = ps_cmd;
                r.sub_command    = ps_sub;
                r.data_byte      = b;
                r.data_index     = ps_count - 16'd1;
                r.payload_length = ps_len;
                expect_item(r);
                if (ps_count == 16'hFFFF || 16'(ps_count + 16'd1) >= ps_len)
                    ps_state = ST_CHECK;
                ps_count = ps_count + 16'd1;
            end
            ST_CHECK: begin
                r.kind           = slcd_pkg::KIND_END;
                r.command        = ps_cmd;
                r.sub_command    = ps_sub;
                r.payload_length = ps_len;
                r.frame_last     = 1'b1;
                r.checksum_good  = ((ps_sum ^ slcd_pkg::BYTE_MASK) == b);
                expect_item(r);
                clear_frame();
            end
            default: clear_frame();
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Presents one byte, optionally after a short idle gap, and waits for the
    // edge that accepts it.
    task automatic send_byte(input logic [7:0] b);
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            i_rx_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_rx_stall);
        predict_byte(b);
        items_sent++;
    endtask

    // Whole frame under the current sync value; corrupt flips one checksum bit.
    task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len,
                              input bit corrupt);
        logic [7:0] sum;
        logic [7:0] b;
        sum = cmd + len[7:0] + len[15:8];
        send_byte(cfg_sync);
        send_byte(cmd);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        for (int i = 0; i < int'(len); i++) begin
            b   = 8'($urandom);
            sum = sum + b;
            send_byte(b);
        end
        b = ~sum;
        if (corrupt)
            b = b ^ 8'(1 << $urandom_range(0, 7));
        send_byte(b);
        frames_sent++;
    endtask

    // Drops valid and waits until every queued item came out and the parser
    // pipeline has emptied, so registers may be written.
    task automatic quiesce();
        i_rx_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_idx == slcd_pkg::REG_SYNC_VALUE)
            cfg_sync = value[7:0];
        else
            cfg_raw = value[0];
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Output side: compare each accepted item, then pick the next stall
    // ------------------------------------------------------------------------
    function automatic void check_field(input string fname, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("output item with nothing expected (kind %0d)", o_out_kind);
                mismatch_count++;
            end else begin
                out_expect = expected_results.pop_front();
                check_field("out_kind",       16'(out_expect.kind),    16'(o_out_kind));
                check_field("command",        16'(out_expect.command), 16'(o_command));
                check_field("sub_command",    16'(out_expect.sub_command),
                            16'(o_sub_command));
                check_field("data_byte",      16'(out_expect.data_byte), 16'(o_data_byte));
                check_field("data_index",     out_expect.data_index,   o_data_index);
                check_field("payload_length", out_expect.payload_length, o_payload_length);
                check_field("frame_last",     16'(out_expect.frame_last), 16'(o_frame_last));
                check_field("checksum_good",  16'(out_expect.checksum_good),
                            16'(o_checksum_good));
                results_checked++;
            end
        end
        i_out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    // Ends the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_rx_valid && !o_rx_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Noise before sync, empty payload, sub-command only, bad checksum and
    // a short payload, all under the reset sync value.
    task automatic test_frame_shapes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(8'hFF, 16'd0, 1'b0);
        send_frame(8'h00, 16'd1, 1'b1);
        send_frame(8'h81, 16'd3, 1'b0);
        quiesce();
    endtask

    // Raw mode entered mid-frame: the partial frame is dropped and the bytes
    // after leaving raw mode are hunted, not parsed.
    task automatic test_raw_switch();
        send_byte(cfg_sync);
        send_byte(8'h3C);
        quiesce();
        write_reg(slcd_pkg::REG_RAW_MODE, 32'h1);
        send_byte(8'hA5);
        quiesce();
        write_reg(slcd_pkg::REG_RAW_MODE, 32'h0);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'h11);
        quiesce();
    endtask

    // Mostly valid frames with random content, plus truncated frames and
    // plain noise; sync value and raw mode change between segments.
    task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                       input int n_items);
        int start;
        int seg_start;
        int pick;
        int len;
        logic [7:0] sync_pick;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        start = items_sent;
        while (items_sent - start < n_items) begin
            quiesce();
            case (seg_count % 5)
                0:       sync_pick = 8'h00;
                1:       sync_pick = 8'hFF;
                2:       sync_pick = slcd_pkg::SYNC_RESET;
                default: sync_pick = 8'($urandom);
            endcase
            write_reg(slcd_pkg::REG_SYNC_VALUE,
                      {8'($urandom_range(0, 255)), 16'h0000, sync_pick});
            write_reg(slcd_pkg::REG_RAW_MODE, 32'((seg_count % 5) == 4));
            seg_start = items_sent;
            while (items_sent - seg_start < SEGMENT_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (cfg_raw) begin
                    send_byte(8'($urandom));
                end else if (pick < 80) begin
                    pick = $urandom_range(0, 99);
                    len  = (pick < 70) ? $urandom_range(0, 8) :
                           (pick < 95) ? $urandom_range(9, 40) : $urandom_range(200, 300);
                    send_frame(8'($urandom), 16'(len), $urandom_range(0, 99) < 20);
                end else begin
                    // truncated frame or bare noise
                    if (pick < 90)
                        send_byte(cfg_sync);
                    repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
                end
            end
            seg_count++;
        end
        quiesce();
    endtask

    // Largest length field: the payload runs for a while, then raw mode
    // abandons the frame before its checksum.
    task automatic test_longest_frame();
        write_reg(slcd_pkg::REG_SYNC_VALUE, 32'(slcd_pkg::SYNC_RESET));
        write_reg(slcd_pkg::REG_RAW_MODE, 32'h0);
        send_byte(cfg_sync);
        send_byte(8'hC3);
        send_byte(8'hFF);
        send_byte(8'hFF);
        repeat (LONG_PAYLOAD) send_byte(8'($urandom));
        quiesce();
        write_reg(slcd_pkg::REG_RAW_MODE, 32'h1);
        send_byte(8'h5A);
        quiesce();
        write_reg(slcd_pkg::REG_RAW_MODE, 32'h0);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        i_rx_valid  <= 1'b0;
        i_rx_byte   <= '0;
        i_out_stall <= 1'b0;
        cfg_sync        = slcd_pkg::SYNC_RESET;
        cfg_raw         = 1'b0;
        clear_frame();
        tx_idle_pct     = 29;
        rx_stall_pct    = 49;
        items_sent      = 0;
        frames_sent     = 0;
        results_checked = 0;
        mismatch_count  = 0;
        quiet_cycles    = 0;
        seg_count       = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_frame_shapes();
        test_raw_switch();
        test_random_traffic(29, 49, 400);
        test_random_traffic(49, 29, 400);
        test_random_traffic(0, 0, 400);
        test_longest_frame();

        // Pipeline is drained; anything left queued was never produced.
        quiesce();
        if (expected_results.size() != 0) begin
            $error("%0d expected items never came out", expected_results.size());
            mismatch_count++;
        end

        $display("Run covered %0d bytes in %0d built frames over %0d register settings,",
                 items_sent, frames_sent, seg_count + 3);
        $display("with %0d output items checked and %0d mismatches.",
                 results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/slcd_pkg.sv
src/slcd_front.sv
src/slcd_queue.sv
src/slcd_back.sv
src/sync_length_checksum_deframer.sv
sim/testbench.sv
